// ===== rtl/ltfa_pkg.sv =====
// ltfa_pkg: shared types and constants for the line to frame assembler
// no dependencies; used by every module of the block by scoped names
package ltfa_pkg;

   localparam int LINE_MAX = 8;
   localparam int FILL_W   = 4;
   localparam int IDX_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_ONE = 8'h31;

   localparam logic [7:0] SYNC_RESET  = 8'h16;
   localparam logic [7:0] START_RESET = 8'h02;
   localparam logic [7:0] END_RESET   = 8'h03;

   localparam logic [CSR_IDX_W-1:0] REG_SYNC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END   = 2'd2;

   // one finished message line with the id it goes out under
   typedef struct packed {
      logic [7:0]                   id;
      logic [LINE_MAX-1:0][7:0]     chars;
      logic [IDX_W-1:0]             len;
   } line_cmd_type;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] start_byte;
      logic [7:0] end_byte;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SYNC,
      BK_START,
      BK_ID,
      BK_DATA,
      BK_END
   } back_state_type;

endpackage

// ===== rtl/line_to_frame_assembler_top.sv =====
// line_to_frame_assembler_top: top level of the line to frame assembler
// depends on ltfa_pkg, ltfa_front, ltfa_queue and ltfa_back
//
// Received characters are taken one per cycle and gathered into lines of up to
// eight characters; a line end is handled in the same cycle it is taken. An
// eight-character line loads the id when none is held and clears a held id
// otherwise; the next shorter line after a loaded id is queued as a message.
// The sender takes each message from the two-entry line queue and emits sync,
// start, id, the message characters and the end byte, one byte per cycle while
// the output is not stalled. Input stalls only while both queue entries wait.
module line_to_frame_assembler_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_of_frame,
   input  logic       csr_write,
   input  logic [ltfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   ltfa_pkg::cfg_type      cfg_ff, cfg_in;
   ltfa_pkg::line_cmd_type push_cmd;
   ltfa_pkg::line_cmd_type q_head;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ltfa_pkg::REG_SYNC:  cfg_in.sync_byte  = csr_wdata;
            ltfa_pkg::REG_START: cfg_in.start_byte = csr_wdata;
            ltfa_pkg::REG_END:   cfg_in.end_byte   = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte  <= ltfa_pkg::SYNC_RESET;
         cfg_ff.start_byte <= ltfa_pkg::START_RESET;
         cfg_ff.end_byte   <= ltfa_pkg::END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ltfa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_char (req_rx_char),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   ltfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   ltfa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("line pushed into a full queue");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("line popped from an empty queue");

   a_full_implies_valid: assert property (@(posedge clock) disable iff (reset)
      q_full |-> (q_valid && req_stall))
      else $error("queue full without stall on the input");

endmodule

// ===== rtl/ltfa_front.sv =====
// ltfa_front: takes characters, builds lines, holds the id and classifies lines
// depends on ltfa_pkg; pushes message lines into ltfa_queue
module ltfa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_char,
   input  logic                  q_full,
   output logic                  q_push,
   output ltfa_pkg::line_cmd_type q_cmd
);

   logic [7:0]                    line_store_ff [ltfa_pkg::LINE_MAX];
   logic [ltfa_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                          id_held_ff, id_held_in;
   logic [7:0]                    id_value_ff, id_value_in;

   logic                          accept;
   logic                          line_end;
   logic                          store_char;
   logic [ltfa_pkg::FILL_W-1:0]   len;
   logic [7:0]                    id_bits;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign line_end   = (req_rx_char == ltfa_pkg::CH_LF || req_rx_char == ltfa_pkg::CH_CR)
                       && (fill_ff != '0);
   assign store_char = !line_end && (fill_ff < ltfa_pkg::FILL_W'(ltfa_pkg::LINE_MAX));

   // length up to the first zero byte
   always_comb begin
      len = fill_ff;
      for (int i = ltfa_pkg::LINE_MAX - 1; i >= 0; i--) begin
         if ((ltfa_pkg::FILL_W'(i) < fill_ff) && (line_store_ff[i] == 8'h00)) begin
            len = ltfa_pkg::FILL_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ltfa_pkg::LINE_MAX; i++) begin
         id_bits[ltfa_pkg::LINE_MAX-1-i] = (line_store_ff[i] == ltfa_pkg::CH_ONE);
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      id_held_in  = id_held_ff;
      id_value_in = id_value_ff;
      q_push      = 1'b0;
      if (accept) begin
         if (line_end) begin
            fill_in = '0;
            if (len == ltfa_pkg::FILL_W'(ltfa_pkg::LINE_MAX)) begin
               if (!id_held_ff) begin
                  id_value_in = id_bits;
                  id_held_in  = 1'b1;
               end else begin
                  id_held_in = 1'b0;
               end
            end else if (id_held_ff) begin
               q_push      = 1'b1;
               id_value_in = '0;
               id_held_in  = 1'b0;
            end
         end else if (store_char) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_comb begin
      q_cmd.id  = id_value_ff;
      q_cmd.len = len[ltfa_pkg::IDX_W-1:0];
      for (int i = 0; i < ltfa_pkg::LINE_MAX; i++) begin
         q_cmd.chars[i] = line_store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         id_held_ff  <= 1'b0;
         id_value_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         id_held_ff  <= id_held_in;
         id_value_ff <= id_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_char) begin
         line_store_ff[fill_ff[ltfa_pkg::IDX_W-1:0]] <= req_rx_char;
      end
   end

endmodule

// ===== rtl/ltfa_queue.sv =====
// ltfa_queue: two-entry queue of message lines between front and back
// depends on ltfa_pkg for the entry type
module ltfa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ltfa_pkg::line_cmd_type push_cmd,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output ltfa_pkg::line_cmd_type head
);

   ltfa_pkg::line_cmd_type entries_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/ltfa_back.sv =====
// ltfa_back: sends one frame per queued message line through an output register
// depends on ltfa_pkg; pops ltfa_queue
module ltfa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ltfa_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   input  ltfa_pkg::line_cmd_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_of_frame
);

   ltfa_pkg::back_state_type state_ff, state_in;
   ltfa_pkg::line_cmd_type   cur_ff;
   logic [ltfa_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               byte_ff;
   logic                     last_ff;

   logic                     slot_free;
   logic                     emit;
   logic [7:0]               emit_byte;
   logic                     emit_last;
   logic                     data_done;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign data_done = (idx_ff == cur_ff.len - 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltfa_pkg::BK_IDLE:  if (q_valid)   state_in = ltfa_pkg::BK_SYNC;
         ltfa_pkg::BK_SYNC:  if (slot_free) state_in = ltfa_pkg::BK_START;
         ltfa_pkg::BK_START: if (slot_free) state_in = ltfa_pkg::BK_ID;
         ltfa_pkg::BK_ID: begin
            if (slot_free) begin
               state_in = (cur_ff.len == '0) ? ltfa_pkg::BK_END : ltfa_pkg::BK_DATA;
            end
         end
         ltfa_pkg::BK_DATA:  if (slot_free && data_done) state_in = ltfa_pkg::BK_END;
         ltfa_pkg::BK_END:   if (slot_free) state_in = ltfa_pkg::BK_IDLE;
         default:            state_in = ltfa_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_byte = '0;
      emit_last = 1'b0;
      case (state_ff)
         ltfa_pkg::BK_IDLE:  q_pop = q_valid;
         ltfa_pkg::BK_SYNC: begin
            emit      = slot_free;
            emit_byte = cfg.sync_byte;
         end
         ltfa_pkg::BK_START: begin
            emit      = slot_free;
            emit_byte = cfg.start_byte;
         end
         ltfa_pkg::BK_ID: begin
            emit      = slot_free;
            emit_byte = cur_ff.id;
         end
         ltfa_pkg::BK_DATA: begin
            emit      = slot_free;
            emit_byte = cur_ff.chars[idx_ff];
         end
         ltfa_pkg::BK_END: begin
            emit      = slot_free;
            emit_byte = cfg.end_byte;
            emit_last = 1'b1;
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) begin
         idx_in = '0;
      end else if (emit && state_ff == ltfa_pkg::BK_DATA) begin
         idx_in = idx_ff + 1'b1;
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltfa_pkg::BK_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (emit) begin
         byte_ff <= emit_byte;
         last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for line_to_frame_assembler_top
// depends on ltfa_pkg and the rtl; predicts every frame byte and checks it in order
module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [ltfa_pkg::CSR_IDX_W-1:0] REG_NONE = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic       rsp_last_of_frame;
   logic       csr_write = 1'b0;
   logic [ltfa_pkg::CSR_IDX_W-1:0] csr_index = ltfa_pkg::REG_SYNC;
   logic [7:0] csr_wdata = 8'h00;

   logic [7:0]     chars_to_send[$];
   frame_byte_type frame_bytes_due[$];
   int             queued_count = 0;
   int             error_count = 0;
   int             cycle_count = 0;

   // predicted block state
   logic [7:0] sync_cfg = ltfa_pkg::SYNC_RESET;
   logic [7:0] start_cfg = ltfa_pkg::START_RESET;
   logic [7:0] end_cfg = ltfa_pkg::END_RESET;
   logic [7:0] held_line[ltfa_pkg::LINE_MAX];
   int         held_count = 0;
   logic       id_taken = 1'b0;
   logic [7:0] id_bits = 8'h00;

   int             gap_left = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;

   line_to_frame_assembler_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_char       (req_rx_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic push_frame_byte(input logic [7:0] b, input logic last);
      frame_byte_type fb;
      fb.data = b;
      fb.last = last;
      frame_bytes_due.push_back(fb);
   endtask

   task automatic assemble_char(input logic [7:0] c);
      int n;
      if ((c == ltfa_pkg::CH_LF || c == ltfa_pkg::CH_CR) && held_count != 0) begin
         n = 0;
         while (n < held_count && held_line[n] != 8'h00)
            n++;
         if (n == ltfa_pkg::LINE_MAX) begin
            if (!id_taken) begin
               for (int i = 0; i < ltfa_pkg::LINE_MAX; i++)
                  id_bits = {id_bits[6:0], held_line[i] == ltfa_pkg::CH_ONE};
               id_taken = 1'b1;
            end else begin
               id_taken = 1'b0;
            end
         end else if (id_taken) begin
            push_frame_byte(sync_cfg, 1'b0);
            push_frame_byte(start_cfg, 1'b0);
            push_frame_byte(id_bits, 1'b0);
            for (int i = 0; i < n; i++)
               push_frame_byte(held_line[i], 1'b0);
            push_frame_byte(end_cfg, 1'b1);
            id_bits = 8'h00;
            id_taken = 1'b0;
         end
         held_count = 0;
      end else if (held_count < ltfa_pkg::LINE_MAX) begin
         held_line[held_count] = c;
         held_count++;
      end
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_valid && !req_stall)
            assemble_char(req_rx_char);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || chars_to_send.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_rx_char <= chars_to_send.pop_front();
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (mode_left % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected frame byte %h last %b", rsp_frame_byte, rsp_last_of_frame);
            error_count++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== want.data) begin
               $error("frame_byte: expected %h, got %h", want.data, rsp_frame_byte);
               error_count++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame: expected %b, got %b", want.last, rsp_last_of_frame);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_char(input logic [7:0] c);
      chars_to_send.push_back(c);
      queued_count++;
   endtask

   function automatic logic [7:0] body_char(input int pos);
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (pos > 0 && (b == ltfa_pkg::CH_LF || b == ltfa_pkg::CH_CR));
      return b;
   endfunction

   task automatic push_terminator();
      push_char($urandom_range(0, 1) ? ltfa_pkg::CH_CR : ltfa_pkg::CH_LF);
   endtask

   // eight characters; now and then a zero spoils it, or extra characters get dropped
   task automatic push_id_line();
      int spoil_at;
      int extra;
      logic [7:0] b;
      spoil_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ltfa_pkg::LINE_MAX - 1) : -1;
      for (int pos = 0; pos < ltfa_pkg::LINE_MAX; pos++) begin
         if (pos == spoil_at)
            push_char(8'h00);
         else
            push_char($urandom_range(0, 1) ? ltfa_pkg::CH_ONE : body_char(pos));
      end
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < extra; i++) begin
         do
            b = 8'($urandom_range(0, 255));
         while (b == ltfa_pkg::CH_LF || b == ltfa_pkg::CH_CR);
         push_char(b);
      end
      push_terminator();
   endtask

   task automatic push_message_line();
      int total;
      int zero_at;
      if ($urandom_range(0, 3) == 0) begin
         total = $urandom_range(1, ltfa_pkg::LINE_MAX);
         zero_at = $urandom_range(0, total - 1);
      end else begin
         total = $urandom_range(1, ltfa_pkg::LINE_MAX - 1);
         zero_at = -1;
      end
      for (int pos = 0; pos < total; pos++)
         push_char(pos == zero_at ? 8'h00 : body_char(pos));
      push_terminator();
   endtask

   task automatic push_random_items(input int target);
      int first;
      int pick;
      int n;
      first = queued_count;
      while (queued_count - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            push_id_line();
            push_message_line();
         end else if (pick < 65) begin
            push_id_line();
            push_id_line();
         end else if (pick < 78) begin
            push_message_line();
         end else if (pick < 88) begin
            push_id_line();
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               push_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_idle();
      while (chars_to_send.size() != 0 || req_valid || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ltfa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == ltfa_pkg::REG_SYNC)
         sync_cfg = value;
      else if (idx == ltfa_pkg::REG_START)
         start_cfg = value;
      else if (idx == ltfa_pkg::REG_END)
         end_cfg = value;
   endtask

   task automatic write_framing(input logic [7:0] s, input logic [7:0] st, input logic [7:0] e);
      write_reg(ltfa_pkg::REG_SYNC, s);
      write_reg(ltfa_pkg::REG_START, st);
      write_reg(ltfa_pkg::REG_END, e);
      write_reg(REG_NONE, 8'($urandom_range(0, 255)));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // id 0xff, with a dropped ninth character
      repeat (ltfa_pkg::LINE_MAX) push_char(ltfa_pkg::CH_ONE);
      push_char(8'hFF);
      push_char(ltfa_pkg::CH_CR);
      // lf on an empty line is data; zero cuts the message short
      push_char(ltfa_pkg::CH_LF);
      push_char(8'h80);
      push_char(8'h00);
      push_char(8'h7F);
      push_char(ltfa_pkg::CH_CR);
      // short line with no id held
      push_char(8'h00);
      push_char(ltfa_pkg::CH_LF);
      // id 0x55, with a dropped ninth character that is zero
      for (int i = 0; i < ltfa_pkg::LINE_MAX; i++)
         push_char(i % 2 ? ltfa_pkg::CH_ONE : 8'h30);
      push_char(8'h00);
      push_char(ltfa_pkg::CH_CR);
      wait_idle();

      write_framing(8'h00, 8'h00, 8'h00);
      push_random_items(120);
      wait_idle();

      write_framing(8'hFF, 8'hFF, 8'hFF);
      push_random_items(120);
      wait_idle();

      write_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      push_random_items(110);
      wait_idle();

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
